// ===== src/bpra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bpra_pkg;

    localparam int PAGE_BYTES  = 4096;
    localparam int NUM_WINDOWS = 4;
    localparam int WIN_PAGES   = 64;

    // Page size is a power of two, so page arithmetic is a shift.
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int POS_W      = $clog2(WIN_PAGES);
    localparam int CNT_W      = POS_W + 1;
    localparam int WIN_W      = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
    localparam int PIDX_W     = WIN_W + POS_W;

    localparam logic [32:0] REGION_BYTES =
        33'(longint'(NUM_WINDOWS) * WIN_PAGES * PAGE_BYTES);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int PADDR_W = 3;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_OUTSIDE  = 2'd2;

    localparam logic REG_REGION_BASE = 1'b0;

    typedef struct packed {
        logic             kind;
        logic             bad;
        logic [WIN_W-1:0] win;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] count;
    } t_entry;

    function automatic logic [WIN_PAGES-1:0] run_mask(input logic [CNT_W-1:0] n);
        logic [WIN_PAGES-1:0] m;
        if (n >= CNT_W'(WIN_PAGES)) begin
            m = '1;
        end else begin
            m = ({{(WIN_PAGES-1){1'b0}}, 1'b1} << n[POS_W-1:0]) - {{(WIN_PAGES-1){1'b0}}, 1'b1};
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== src/bitmap_page_run_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path from input beat to result beat: input register, queue, then a window scan that visits
// one window per scan step; release and bad items end at the first scan step.
// A new item is taken only when the scan is idle, so items are handled one at a time.
// Reset (synchronous, active low): every page free, region_base 0, queue and result empty.

module bitmap_page_run_allocator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bpra_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_kind,
    input  wire logic [31:0]                   i_page_addr,
    input  wire logic [bpra_pkg::CNT_W-1:0]    i_page_count,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [1:0]                         o_status,
    output logic [31:0]                        o_alloc_addr
);
    import bpra_pkg::*;

    logic [31:0] r_region_base;
    logic        sel_base;
    logic        push_valid;
    logic        push_ready;
    t_entry      push_data;
    logic        pop_valid;
    logic        pop_ready;
    t_entry      pop_data;

    assign pready   = 1'b1;
    assign sel_base = (paddr[PADDR_W-1] == REG_REGION_BASE);
    assign prdata   = sel_base ? r_region_base : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base <= '0;
        end else if (psel && penable && pwrite && pready && sel_base) begin
            r_region_base <= pwdata;
        end
    end

    bpra_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_region_base (r_region_base),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_page_addr   (i_page_addr),
        .i_page_count  (i_page_count),
        .o_push_valid  (push_valid),
        .i_push_ready  (push_ready),
        .o_push_data   (push_data)
    );

    bpra_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    bpra_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_region_base (r_region_base),
        .i_pop_valid   (pop_valid),
        .o_pop_ready   (pop_ready),
        .i_pop_data    (pop_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_alloc_addr  (o_alloc_addr)
    );

endmodule

`default_nettype wire

// ===== src/bpra_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpra_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [31:0]              i_region_base,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_kind,
    input  wire logic [31:0]              i_page_addr,
    input  wire logic [bpra_pkg::CNT_W-1:0] i_page_count,
    output logic                          o_push_valid,
    input  wire logic                     i_push_ready,
    output bpra_pkg::t_entry              o_push_data
);
    import bpra_pkg::*;

    logic        r_valid;
    t_entry      r_ent;
    t_entry      n_ent;
    logic [32:0] offset;
    logic [PIDX_W-1:0] page;
    logic        outside;
    logic        bad_count;
    logic        take;

    assign o_in_ready   = !r_valid || i_push_ready;
    assign take         = i_in_valid && o_in_ready;
    assign o_push_valid = r_valid;
    assign o_push_data  = r_ent;

    always_comb begin
        offset    = {1'b0, i_page_addr} - {1'b0, i_region_base};
        // A borrow out of the subtract means the address lies below the base.
        outside   = offset[32] || ({1'b0, offset[31:0]} >= REGION_BYTES);
        page      = offset[PAGE_SHIFT +: PIDX_W];
        bad_count = (i_page_count == '0) || (i_page_count > CNT_W'(WIN_PAGES));
        n_ent.kind  = i_kind;
        n_ent.bad   = (i_kind == KIND_RELEASE) ? outside : bad_count;
        n_ent.win   = page[PIDX_W-1 -: WIN_W];
        n_ent.pos   = page[POS_W-1:0];
        n_ent.count = i_page_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ent <= n_ent;
        end
    end

endmodule

`default_nettype wire

// ===== src/bpra_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpra_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push_valid,
    output logic                  o_push_ready,
    input  wire bpra_pkg::t_entry i_push_data,
    output logic                  o_pop_valid,
    input  wire logic             i_pop_ready,
    output bpra_pkg::t_entry      o_pop_data
);
    import bpra_pkg::*;

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_cnt;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_cnt != QCNT_W'(QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/bpra_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpra_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [31:0]      i_region_base,
    input  wire logic             i_pop_valid,
    output logic                  o_pop_ready,
    input  wire bpra_pkg::t_entry i_pop_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [1:0]            o_status,
    output logic [31:0]           o_alloc_addr
);
    import bpra_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                 r_state;
    logic                 n_state;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_entry               r_cur;
    logic [WIN_W-1:0]     r_win;
    logic [1:0]           r_status;
    logic [31:0]          r_addr;
    logic [WIN_PAGES-1:0] r_map [NUM_WINDOWS];

    logic [WIN_PAGES-1:0] win_map;
    logic [WIN_PAGES-1:0] run_m;
    logic [WIN_PAGES-1:0] cand;
    logic                 hit;
    logic [POS_W-1:0]     hit_pos;
    logic                 last_win;
    logic                 finish;
    logic                 pop;
    logic [PIDX_W-1:0]    hit_page;
    logic [31:0]          hit_addr;

    assign o_pop_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign pop          = i_pop_valid && o_pop_ready;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_alloc_addr = r_addr;

    // Each scan cycle looks at one window: every start position is tested
    // at once and the lowest fitting one wins.
    always_comb begin
        win_map = r_map[r_win];
        run_m   = run_mask(r_cur.count);
        for (int i = 0; i < WIN_PAGES; i++) begin
            cand[i] = ((CNT_W + 1)'(i) + {1'b0, r_cur.count} <= (CNT_W + 1)'(WIN_PAGES)) &&
                      (((win_map >> i) & run_m) == run_m);
        end
        hit     = |cand;
        hit_pos = '0;
        for (int i = WIN_PAGES - 1; i >= 0; i--) begin
            if (cand[i]) begin
                hit_pos = POS_W'(i);
            end
        end
        hit_page = {r_win, hit_pos};
        hit_addr = i_region_base + (32'(hit_page) << PAGE_SHIFT);
        last_win = (r_win == WIN_W'(NUM_WINDOWS - 1));
        finish   = (r_state == S_SCAN) &&
                   (r_cur.bad || (r_cur.kind == KIND_RELEASE) || hit || last_win);
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (pop) begin
            n_state = S_SCAN;
        end else if (finish) begin
            n_state     = S_IDLE;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int w = 0; w < NUM_WINDOWS; w++) begin
                r_map[w] <= '1;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if ((r_state == S_SCAN) && !r_cur.bad) begin
                if (r_cur.kind == KIND_RELEASE) begin
                    r_map[r_cur.win] <= r_map[r_cur.win] |
                                        (run_mask(r_cur.count) << r_cur.pos);
                end else if (hit) begin
                    r_map[r_win] <= win_map & ~(run_m << hit_pos);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur <= i_pop_data;
            r_win <= '0;
        end else if ((r_state == S_SCAN) && !finish) begin
            r_win <= r_win + 1'b1;
        end
        if (finish) begin
            r_addr <= '0;
            if (r_cur.bad) begin
                r_status <= (r_cur.kind == KIND_RELEASE) ? ST_OUTSIDE : ST_NO_SPACE;
            end else if (r_cur.kind == KIND_RELEASE) begin
                r_status <= ST_DONE;
            end else if (hit) begin
                r_status <= ST_DONE;
                r_addr   <= hit_addr;
            end else begin
                r_status <= ST_NO_SPACE;
            end
        end
    end

    a_scan_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_out_valid)
        else $error("scan running while a result is still held");

    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_state == S_SCAN))
        else $error("popped entry did not start a scan");

    a_addr_only_on_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != ST_DONE)) |-> (r_addr == '0))
        else $error("nonzero address on a failed result");

    a_finish_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> r_out_valid)
        else $error("finished item produced no result");

endmodule

`default_nettype wire
